/* rtl/core/tlb_page_table_translator_defines.svh */
// Assertion macros shared by the verification files of the address translator.
// Depends on nothing; the including module must provide clk and rst.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tpt_pkg.sv */
// Shared constants and types for the address translator.
// Depends on nothing; used by the TLB and the top level.
package tpt_pkg;

  localparam int ADDR_W       = 16;
  localparam int FRAME_BYTES  = 256;
  localparam int PAGE_ENTRIES = 256;
  localparam int TLB_ENTRIES  = 16;
  localparam int OFFSET_W     = $clog2(FRAME_BYTES);
  localparam int PAGE_W       = $clog2(PAGE_ENTRIES);
  localparam int TLB_IDX_W    = $clog2(TLB_ENTRIES);
  localparam int FRAME_W      = 8;
  localparam int NFF_W        = FRAME_W + 1;
  localparam int CNT_W        = 32;

  // Result of an associative TLB search.
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_lookup_t;

  // FIFO refill request for the TLB.
  typedef struct packed {
    logic               en;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_fill_t;

endpackage

/* rtl/core/tlb_page_table_translator.sv */
// Channel     Signals                                   Handshake
// request     start, busy, logical_address              start high while busy low
// result      done, physical_address, frame_number,     done strobe, one cycle
//             tlb_hit, page_fault, hits_so_far, faults_so_far
//
// Each transaction has a lookup cycle that searches the TLB and reads the page
// table memory, and a resolve cycle that allocates a frame and writes the page
// table on a fault and refills the TLB on a TLB miss. The page table read is
// registered. The result strobes in the cycle after resolve, and a new
// transaction may start in that same cycle.
// Reset is synchronous and clears all valid bits at once, with no clearing
// pass. The receiver cannot stall; every result is taken when it is shown.
// Depends on tpt_pkg and tpt_tlb.
module tlb_page_table_translator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tpt_pkg::ADDR_W-1:0]    logical_address,
  output logic                          done,
  output logic [tpt_pkg::ADDR_W-1:0]    physical_address,
  output logic [tpt_pkg::FRAME_W-1:0]   frame_number,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [tpt_pkg::CNT_W-1:0]     hits_so_far,
  output logic [tpt_pkg::CNT_W-1:0]     faults_so_far
);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  localparam logic [tpt_pkg::NFF_W-1:0] NFF_MAX = '1;
  localparam logic [tpt_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic                                state;
  logic                                accept;
  logic [tpt_pkg::PAGE_W-1:0]          page_in;
  tpt_pkg::tlb_lookup_t                lookup;
  tpt_pkg::tlb_fill_t                  fill;

  // Lookup-cycle registers.
  logic [tpt_pkg::PAGE_W-1:0]          page_q;
  logic [tpt_pkg::OFFSET_W-1:0]        offset_q;
  logic                                hit_q;
  logic [tpt_pkg::FRAME_W-1:0]         tlb_frame_q;
  logic                                pt_hit_q;
  logic [tpt_pkg::FRAME_W-1:0]         pt_rdata;

  // Page table storage.
  logic [tpt_pkg::FRAME_W-1:0]         pt_mem [tpt_pkg::PAGE_ENTRIES];
  logic [tpt_pkg::PAGE_ENTRIES-1:0]    pt_valid;

  logic [tpt_pkg::NFF_W-1:0]           next_free;
  logic [tpt_pkg::NFF_W-1:0]           next_free_next;
  logic [tpt_pkg::CNT_W-1:0]           hit_count;
  logic [tpt_pkg::CNT_W-1:0]           hit_count_next;
  logic [tpt_pkg::CNT_W-1:0]           fault_count;
  logic [tpt_pkg::CNT_W-1:0]           fault_count_next;

  logic                                resolve;
  logic                                fault;
  logic [tpt_pkg::FRAME_W-1:0]         frame;

  assign busy    = (state == ST_RESOLVE);
  assign accept  = start && (state == ST_IDLE);
  assign resolve = (state == ST_RESOLVE);
  assign page_in = tpt_pkg::PAGE_W'(logical_address >> tpt_pkg::OFFSET_W);

  tpt_tlb u_tlb (
    .clk    (clk),
    .rst    (rst),
    .page   (page_in),
    .lookup (lookup),
    .fill   (fill)
  );

  // Sequencer: a lookup cycle, then a resolve cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the TLB result and read the page table at the accepted page.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_q      <= page_in;
      offset_q    <= tpt_pkg::OFFSET_W'(logical_address);
      hit_q       <= lookup.hit;
      tlb_frame_q <= lookup.frame;
      pt_rdata    <= pt_mem[page_in];
    end
  end

  // Page table valid bits sit in flip-flops so that reset clears them at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= '0;
      pt_hit_q <= 1'b0;
    end else begin
      if (accept) begin
        pt_hit_q <= pt_valid[page_in];
      end
      if (resolve && fault) begin
        pt_valid[page_q] <= 1'b1;
      end
    end
  end

  // A fault writes the newly allocated frame into the page table.
  always_ff @(posedge clk) begin
    if (resolve && fault) begin
      pt_mem[page_q] <= next_free[tpt_pkg::FRAME_W-1:0];
    end
  end

  // Resolve the frame and the counter updates.
  always_comb begin
    fault = !hit_q && !pt_hit_q;
    if (hit_q) begin
      frame = tlb_frame_q;
    end else if (pt_hit_q) begin
      frame = pt_rdata;
    end else begin
      frame = next_free[tpt_pkg::FRAME_W-1:0];
    end

    next_free_next   = next_free;
    hit_count_next   = hit_count;
    fault_count_next = fault_count;
    if (hit_q && (hit_count != CNT_MAX)) begin
      hit_count_next = hit_count + 1'b1;
    end
    if (fault) begin
      if (fault_count != CNT_MAX) begin
        fault_count_next = fault_count + 1'b1;
      end
      if (next_free != NFF_MAX) begin
        next_free_next = next_free + 1'b1;
      end
    end

    fill.en    = resolve && !hit_q;
    fill.page  = page_q;
    fill.frame = frame;
  end

  // Allocation pointer and counters, plus the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free   <= '0;
      hit_count   <= '0;
      fault_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= resolve;
      if (resolve) begin
        next_free   <= next_free_next;
        hit_count   <= hit_count_next;
        fault_count <= fault_count_next;
      end
    end
  end

  // Result registers hold the transaction until the next one resolves.
  always_ff @(posedge clk) begin
    if (resolve) begin
      physical_address <= tpt_pkg::ADDR_W'({frame, offset_q});
      frame_number     <= frame;
      tlb_hit          <= hit_q;
      page_fault       <= fault;
      hits_so_far      <= hit_count_next;
      faults_so_far    <= fault_count_next;
    end
  end

endmodule

/* rtl/core/tpt_tlb.sv */
// Fully associative TLB with FIFO replacement and first-match lookup.
// Depends on tpt_pkg for widths, depth and the lookup and fill structs.
module tpt_tlb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tpt_pkg::PAGE_W-1:0]        page,
  output tpt_pkg::tlb_lookup_t              lookup,
  input  tpt_pkg::tlb_fill_t                fill
);

  logic [tpt_pkg::PAGE_W-1:0]    tags   [tpt_pkg::TLB_ENTRIES];
  logic [tpt_pkg::FRAME_W-1:0]   frames [tpt_pkg::TLB_ENTRIES];
  logic [tpt_pkg::TLB_ENTRIES-1:0] valid;
  logic [tpt_pkg::TLB_IDX_W-1:0] fill_ptr;
  logic [tpt_pkg::TLB_IDX_W-1:0] fill_ptr_next;

  // Compare every entry in parallel; the lowest valid match wins.
  always_comb begin
    lookup.hit   = 1'b0;
    lookup.frame = '0;
    for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++) begin
      if (!lookup.hit && valid[i] && (tags[i] == page)) begin
        lookup.hit   = 1'b1;
        lookup.frame = frames[i];
      end
    end
  end

  // The fill pointer wraps after the last entry.
  always_comb begin
    if (fill_ptr == tpt_pkg::TLB_IDX_W'(tpt_pkg::TLB_ENTRIES - 1)) begin
      fill_ptr_next = '0;
    end else begin
      fill_ptr_next = fill_ptr + 1'b1;
    end
  end

  // Valid bits and the pointer are control state and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fill_ptr <= '0;
    end else if (fill.en) begin
      valid[fill_ptr] <= 1'b1;
      fill_ptr        <= fill_ptr_next;
    end
  end

  // Tag and frame storage needs no reset.
  always_ff @(posedge clk) begin
    if (fill.en) begin
      tags[fill_ptr]   <= fill.page;
      frames[fill_ptr] <= fill.frame;
    end
  end

endmodule

/* rtl/core/tpt_checker.sv */
// Port-level checker for the address translator, bound to the top level.
// Depends on tpt_pkg and the assertion macros in the defines header.
`include "tlb_page_table_translator_defines.svh"

module tpt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        tlb_hit,
  input logic                        page_fault,
  input logic [tpt_pkg::CNT_W-1:0]   faults_so_far
);

  // An accepted transaction moves the block to busy, its resolve cycle, with done still low.
  `TPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not go busy")

  // The resolve cycle is always followed by the result strobe.
  `TPT_ASSERT_NEXT(a_busy_done, busy, done && !busy, "resolve did not strobe a result")

  // A TLB hit never reports a page fault.
  `TPT_ASSERT_NOW(a_hit_no_fault, done && tlb_hit, !page_fault, "fault flagged on a TLB hit")

  // A reported fault is always counted.
  `TPT_ASSERT_NOW(a_fault_counted, done && page_fault, faults_so_far != '0, "fault not counted")

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .tlb_hit       (tlb_hit),
  .page_fault    (page_fault),
  .faults_so_far (faults_so_far)
);
